// ----- hw/rtl/itr_pkg.sv -----
package itr_pkg;

    // Default input width and register reset value
    localparam int unsigned VALUE_WIDTH_DEFAULT = 32;
    localparam int unsigned RADIX_WIDTH         = 6;
    localparam int unsigned CHAR_WIDTH          = 7;
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] DIGIT_MAX   = 6'd35;

    // ASCII codes
    localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 7'h61;

    // Status from the shared divider: one-cycle done pulse and remainder
    typedef struct packed {
        logic                   done;
        logic [RADIX_WIDTH-1:0] rem;
    } div_stat_t;

    // Digit value to lowercase ASCII character
    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
        logic [RADIX_WIDTH-1:0] dc;
        dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
        if (dc < 6'd10)
            return CHAR_ZERO + {1'b0, dc};
        else
            return CHAR_A + {1'b0, dc} - 7'd10;
    endfunction

endpackage

// ----- hw/rtl/itr_divider.sv -----
// Restoring divider: one quotient bit per cycle
module itr_divider #(
    parameter int unsigned VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [VALUE_WIDTH-1:0]            dividend,
    input  logic [itr_pkg::RADIX_WIDTH-1:0]   divisor,
    output logic [VALUE_WIDTH-1:0]            quotient,
    output itr_pkg::div_stat_t                stat
);

    localparam int unsigned IW = $clog2(VALUE_WIDTH);
    localparam int unsigned RW = itr_pkg::RADIX_WIDTH;

    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [IW-1:0]          iter_reg, iter_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [RW:0]            trial;
    logic [RW:0]            diff;
    logic                   fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            iter_next = IW'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? diff[RW-1:0] : trial[RW-1:0];
            if (iter_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                iter_next = iter_reg - IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

// ----- hw/rtl/integer_to_text_radix.sv -----
// Signed integer to ASCII text in a programmable base (2 to 36).
//
// Channels: number in on in_valid/in_stall, characters out on
// out_valid/out_stall (char_code, last), radix written on cfg_valid/cfg_ready.
// Each input transaction yields an optional '-', the digits most significant
// first (lowercase letters above 9), then a NUL with last = 1. A radix
// outside 2..36 yields only the NUL.
// Digits come from one shared restoring divider that produces a quotient bit
// per cycle; each remainder is stored as a digit and the quotient is divided
// again until it is zero or VALUE_WIDTH digits are stored.
// The input is stalled while a conversion is running; a new number is taken
// as soon as the terminator sits in the output register.
// Output stall holds the output register and pauses character emission.
// Reset clears the sequencer and output valid and sets radix to 10; the
// radix port is ready only while no conversion runs.
module integer_to_text_radix #(
    parameter int unsigned VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [VALUE_WIDTH-1:0]            number,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [itr_pkg::CHAR_WIDTH-1:0]    char_code,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [itr_pkg::RADIX_WIDTH-1:0]   radix
);

    localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned AW = $clog2(VALUE_WIDTH);
    localparam int unsigned RW = itr_pkg::RADIX_WIDTH;
    localparam int unsigned XW = itr_pkg::CHAR_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT,
        S_TERM
    } state_t;

    state_t          state_reg, state_next;
    logic [RW-1:0]   radix_reg, radix_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            neg_reg, neg_next;
    logic            out_valid_reg, out_valid_next;
    logic [XW-1:0]   char_reg, char_next;
    logic            last_reg, last_next;

    logic [CW-1:0]   cnt_inc;
    logic [CW-1:0]   cnt_dec;
    logic            out_free;
    logic            radix_ok;
    logic [VALUE_WIDTH-1:0] magnitude;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quo;
    itr_pkg::div_stat_t     div_stat;

    // Digit store
    logic [RW-1:0]   digit_mem [VALUE_WIDTH];
    logic            mem_we;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [RW-1:0]   rd_data_reg;

    itr_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign cnt_inc   = count_reg + CW'(1);
    assign cnt_dec   = count_reg - CW'(1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign radix_ok  = (radix_reg >= itr_pkg::RADIX_MIN) && (radix_reg <= itr_pkg::RADIX_MAX);
    assign magnitude = number[VALUE_WIDTH-1] ? (~number + VALUE_WIDTH'(1)) : number;
    assign div_dividend = (state_reg == S_IDLE) ? magnitude : div_quo;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        div_start      = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cnt_dec[AW-1:0];

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid && cfg_ready)
            radix_next = radix;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!radix_ok)
                    begin
                        state_next = S_TERM;
                    end
                    else
                    begin
                        neg_next   = number[VALUE_WIDTH-1];
                        count_next = '0;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    mem_we     = 1'b1;
                    count_next = cnt_inc;
                    if ((div_quo != '0) && (cnt_inc != CW'(VALUE_WIDTH)))
                        div_start = 1'b1;
                    else
                        state_next = neg_reg ? S_SIGN : S_READ;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itr_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                count_next = cnt_dec;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itr_pkg::digit_char(rd_data_reg);
                    last_next      = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = S_TERM;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        count_next = cnt_dec;
                    end
                end
            end
            S_TERM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itr_pkg::CHAR_NUL;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= itr_pkg::RADIX_RESET;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= itr_pkg::CHAR_NUL;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    // Digit store: write on divider done, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[count_reg[AW-1:0]] <= div_stat.rem;
        if (rd_en)
            rd_data_reg <= digit_mem[rd_addr];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> char_code == itr_pkg::CHAR_NUL)
        else $error("terminator carries a non-NUL character");

    a_body_not_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> char_code != itr_pkg::CHAR_NUL)
        else $error("NUL emitted without last");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DIV || state_reg == S_TERM)
        else $error("accepted transaction did not start a conversion");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(VALUE_WIDTH))
        else $error("digit count exceeds store depth");
`endif

endmodule
